[hw/rtl/bowl_pkg.sv]
// Shared constants, types and helpers for the bag-of-words logistic classifier.
// Holds the sigmoid table, built at elaboration. No dependencies.
`default_nettype none

package bowl_pkg;

    localparam int VOCAB_SIZE      = 4096;
    localparam int SIGMOID_ENTRIES = 1024;

    localparam int VOCAB_AW  = $clog2(VOCAB_SIZE);
    localparam int PTR_W     = VOCAB_AW + 1;
    localparam int SIG_AW    = $clog2(SIGMOID_ENTRIES);
    localparam int SIG_SHIFT = 20 - SIG_AW;

    localparam int TOKEN_W    = 12;
    localparam int CNT_W      = 8;
    localparam int WGT_W      = 32;
    localparam int PROB_W     = 16;
    localparam int LR_W       = 16;
    localparam int EPS_W      = 15;
    localparam int ACC_W      = 54;
    localparam int MAC_W      = CNT_W + 1 + WGT_W;
    localparam int S_W        = 53;
    localparam int PROD_W     = S_W + CNT_W + 1;
    localparam int SUM_W      = WGT_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_EPSILON  = 2'd1;

    localparam logic [LR_W-1:0]  LR_RESET  = 16'd655;
    localparam logic [EPS_W-1:0] EPS_RESET = 15'd1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [PROB_W-1:0] sig_rom_t [SIGMOID_ENTRIES];

    // e^-a, a in Q16 (0..8), Q0.32 result: Taylor at a/256, then squared 8 times
    function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
        logic [63:0]  y;
        logic [63:0]  y2;
        logic [63:0]  y3;
        logic [63:0]  y4;
        logic [63:0]  e;
        logic [127:0] sq;
        y  = a << 8;
        y2 = (y * y) >> 32;
        y3 = (y2 * y) >> 32;
        y4 = (y3 * y) >> 32;
        e  = (64'd1 << 32) - y + (y2 >> 1) - y3 / 64'd6 + y4 / 64'd24;
        for (int k = 0; k < 8; k++)
        begin
            if (e > 64'hFFFF_FFFF)
                e = 64'hFFFF_FFFF;
            sq = 128'(e) * 128'(e);
            e  = sq[95:32];
        end
        if (e > 64'hFFFF_FFFF)
            e = 64'hFFFF_FFFF;
        return e;
    endfunction

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [PROB_W-1:0] sig_entry(input int i);
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] p;
        logic        neg;
        t   = (64'(2 * i + 1) << 19) / SIGMOID_ENTRIES;
        neg = t < (64'd1 << 19);
        a   = neg ? (64'd1 << 19) - t : t - (64'd1 << 19);
        if (a > (64'd1 << 19))
            a = 64'd1 << 19;
        e = exp_neg_q32(a);
        d = (64'd1 << 32) + e;
        if (!neg)
            num = (64'd1 << 48) + (d >> 1);
        else
            num = (e << 16) + (d >> 1);
        p = udiv64(num, d);
        if (p > 64'd65535)
            p = 64'd65535;
        return p[PROB_W-1:0];
    endfunction

    function automatic sig_rom_t build_sig_rom();
        sig_rom_t r;
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
            r[i] = sig_entry(i);
        return r;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

    // Q48 -> Q16, half away from zero
    function automatic logic signed [SUM_W-1:0] round_q48(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] r;
        m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        r = (m + (PROD_W'(1) << 31)) >> 32;
        return v[PROD_W-1] ? -$signed(r[SUM_W-1:0]) : $signed(r[SUM_W-1:0]);
    endfunction

    function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [SUM_W-1:0] v);
        if (v > $signed(SUM_W'(32'h7FFF_FFFF)))
            return 32'sh7FFF_FFFF;
        else if (v < -$signed(SUM_W'(33'h8000_0000)))
            return 32'sh8000_0000;
        else
            return v[WGT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bowl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-before-write on a shared address. No dependencies.
`default_nettype none

module bowl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/bag_of_words_logistic_sgd.sv]
// Top level of the bag-of-words logistic regression classifier with SGD update.
// Depends on bowl_pkg and bowl_ram (count memory and weight memory).
//
//  channel   handshake                 word
//  -------   ------------------------  ---------------------------------------------
//  token     start & !busy             func token_index token_valid sample_label last_token
//  result    done (one-cycle strobe)   predicted_label probability matches_label
//  config    cfg_valid & cfg_ready     cfg_index cfg_data
//
// Tokens go in one per cycle while busy is low; each does a read-modify-write of
// its count with forwarding between neighbors. A last token holds busy for two
// passes over both memories: one forms the score, one more applies the gradient
// (if func is set) and clears the counts (done pulses between the two passes).
// After reset a clearing pass zeroes both memories; busy is high.
// Config words are taken while busy is low.
`default_nettype none

module bag_of_words_logistic_sgd
    import bowl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  func,
    input  wire logic [TOKEN_W-1:0]    token_index,
    input  wire logic                  token_valid,
    input  wire logic                  sample_label,
    input  wire logic                  last_token,
    output logic                       done,
    output logic                       predicted_label,
    output logic [PROB_W-1:0]          probability,
    output logic                       matches_label,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETTLE,
        ST_SCORE,
        ST_SIG,
        ST_GRAD1,
        ST_GRAD2,
        ST_GRAD3,
        ST_TRAIN
    } state_t;

    state_t state_reg;

    logic [PTR_W-1:0]  ptr_reg;
    logic [LR_W-1:0]   lr_reg;
    logic [EPS_W-1:0]  eps_reg;

    // token count pipeline
    logic                tk_v_reg;
    logic [VOCAB_AW-1:0] tk_idx_reg;
    logic                fw_v_reg;
    logic [VOCAB_AW-1:0] fw_idx_reg;
    logic [CNT_W-1:0]    fw_val_reg;

    // sample state
    logic train_reg;
    logic label_reg;
    logic signed [WGT_W-1:0] bias_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // score pass
    logic                    sc1_v_reg;
    logic                    sc2_v_reg;
    logic signed [MAC_W-1:0] mac_reg;

    // gradient
    logic [PROB_W-1:0]       prob_reg;
    logic signed [17:0]      err_reg;
    logic [16:0]             g_reg;
    logic signed [34:0]      el_reg;
    logic signed [S_W-1:0]   s_reg;

    // train pass
    logic                     tr1_v_reg;
    logic                     tr2_v_reg;
    logic [VOCAB_AW-1:0]      tr1_addr_reg;
    logic [VOCAB_AW-1:0]      tr2_addr_reg;
    logic                     tr2_nz_reg;
    logic signed [PROD_W-1:0] tr2_prod_reg;
    logic signed [WGT_W-1:0]  tr2_w_reg;

    logic done_reg;
    logic pred_reg;
    logic match_reg;

    // memory ports
    logic                cnt_we;
    logic [VOCAB_AW-1:0] cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [VOCAB_AW-1:0] cnt_raddr;
    logic [CNT_W-1:0]    cnt_rdata;
    logic                wgt_we;
    logic [VOCAB_AW-1:0] wgt_waddr;
    logic [WGT_W-1:0]    wgt_wdata;
    logic [WGT_W-1:0]    wgt_rdata;

    logic [CNT_W-1:0] cnt_cur;
    logic [CNT_W-1:0] cnt_inc;
    logic             tok_accept;
    logic             ptr_end;

    logic [SIG_AW-1:0]       sig_idx;
    logic signed [ACC_W-1:0] z_off;

    logic [16:0] pc;
    logic [16:0] hi;
    logic [33:0] g_full;

    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] b_sum;

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign tok_accept = start && !busy;
    assign ptr_end    = (ptr_reg == PTR_W'(VOCAB_SIZE));

    assign done            = done_reg;
    assign predicted_label = pred_reg;
    assign probability     = prob_reg;
    assign matches_label   = match_reg;

    // forward the count written last cycle; the RAM returns the old word there
    assign cnt_cur = (fw_v_reg && fw_idx_reg == tk_idx_reg) ? fw_val_reg : cnt_rdata;
    assign cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);

    always_comb
    begin
        cnt_raddr = (state_reg == ST_IDLE) ? token_index[VOCAB_AW-1:0] : ptr_reg[VOCAB_AW-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = tk_idx_reg;
        cnt_wdata = cnt_inc;
        if (tk_v_reg)
        begin
            cnt_we = 1'b1;
        end
        else if (state_reg == ST_CLEAR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = ptr_reg[VOCAB_AW-1:0];
            cnt_wdata = '0;
        end
        else if (tr1_v_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = tr1_addr_reg;
            cnt_wdata = '0;
        end
    end

    assign w_sum = $signed({{2{tr2_w_reg[WGT_W-1]}}, tr2_w_reg}) + round_q48(tr2_prod_reg);
    assign b_sum = $signed({{2{bias_reg[WGT_W-1]}}, bias_reg})
                 + round_q48(PROD_W'(s_reg));

    always_comb
    begin
        wgt_we    = 1'b0;
        wgt_waddr = tr2_addr_reg;
        wgt_wdata = sat_wgt(w_sum);
        if (state_reg == ST_CLEAR)
        begin
            wgt_we    = 1'b1;
            wgt_waddr = ptr_reg[VOCAB_AW-1:0];
            wgt_wdata = '0;
        end
        else if (tr2_v_reg && train_reg && tr2_nz_reg)
        begin
            wgt_we = 1'b1;
        end
    end

    // table index: clamp outside [-8, 8), else (z + 8) scaled to the table
    always_comb
    begin
        z_off = acc_reg + ACC_W'(1 << 19);
        if (acc_reg < -$signed(ACC_W'(1 << 19)))
            sig_idx = '0;
        else if (acc_reg >= $signed(ACC_W'(1 << 19)))
            sig_idx = SIG_AW'(SIGMOID_ENTRIES - 1);
        else
            sig_idx = z_off[SIG_SHIFT +: SIG_AW];
    end

    always_comb
    begin
        hi = 17'd65536 - 17'(eps_reg);
        pc = 17'(prob_reg);
        if (pc > hi)
            pc = hi;
        if (pc < 17'(eps_reg))
            pc = 17'(eps_reg);
        g_full = 34'(pc) * 34'(17'd65536 - pc);
    end

    bowl_ram #(.WIDTH(CNT_W), .DEPTH(VOCAB_SIZE)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    bowl_ram #(.WIDTH(WGT_W), .DEPTH(VOCAB_SIZE)) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (wgt_wdata),
        .raddr (ptr_reg[VOCAB_AW-1:0]),
        .rdata (wgt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ptr_reg      <= '0;
            lr_reg       <= LR_RESET;
            eps_reg      <= EPS_RESET;
            tk_v_reg     <= 1'b0;
            tk_idx_reg   <= '0;
            fw_v_reg     <= 1'b0;
            fw_idx_reg   <= '0;
            fw_val_reg   <= '0;
            train_reg    <= 1'b0;
            label_reg    <= 1'b0;
            bias_reg     <= '0;
            acc_reg      <= '0;
            sc1_v_reg    <= 1'b0;
            sc2_v_reg    <= 1'b0;
            mac_reg      <= '0;
            prob_reg     <= '0;
            err_reg      <= '0;
            g_reg        <= '0;
            el_reg       <= '0;
            s_reg        <= '0;
            tr1_v_reg    <= 1'b0;
            tr2_v_reg    <= 1'b0;
            tr1_addr_reg <= '0;
            tr2_addr_reg <= '0;
            tr2_nz_reg   <= 1'b0;
            tr2_prod_reg <= '0;
            tr2_w_reg    <= '0;
            done_reg     <= 1'b0;
            pred_reg     <= 1'b0;
            match_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_SIG);

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LEARNING_RATE: lr_reg  <= cfg_data[LR_W-1:0];
                    CFG_CLIP_EPSILON:  eps_reg <= cfg_data[EPS_W-1:0];
                    default: ;
                endcase
            end

            tk_v_reg   <= tok_accept && token_valid
                          && ({1'b0, token_index} < 13'(VOCAB_SIZE));
            tk_idx_reg <= token_index[VOCAB_AW-1:0];
            fw_v_reg   <= tk_v_reg;
            fw_idx_reg <= tk_idx_reg;
            fw_val_reg <= cnt_inc;

            // score pass pipeline: read, multiply, accumulate
            sc1_v_reg <= (state_reg == ST_SCORE) && !ptr_end;
            sc2_v_reg <= sc1_v_reg;
            mac_reg   <= $signed({1'b0, cnt_rdata}) * $signed(wgt_rdata);
            if (sc2_v_reg)
                acc_reg <= acc_reg + ACC_W'(mac_reg);

            // train pass pipeline: read, scale by count, round/add/write
            tr1_v_reg    <= (state_reg == ST_TRAIN) && !ptr_end;
            tr2_v_reg    <= tr1_v_reg;
            tr2_addr_reg <= tr1_addr_reg;
            tr2_nz_reg   <= (cnt_rdata != '0);
            tr2_prod_reg <= s_reg * $signed({1'b0, cnt_rdata});
            tr2_w_reg    <= wgt_rdata;
            tr1_addr_reg <= ptr_reg[VOCAB_AW-1:0];

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (ptr_reg == PTR_W'(VOCAB_SIZE - 1))
                    begin
                        ptr_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + PTR_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (tok_accept && last_token)
                    begin
                        train_reg <= func;
                        label_reg <= sample_label;
                        state_reg <= ST_SETTLE;
                    end
                end
                ST_SETTLE:
                begin
                    // last count write lands this cycle
                    acc_reg   <= ACC_W'(bias_reg);
                    ptr_reg   <= '0;
                    state_reg <= ST_SCORE;
                end
                ST_SCORE:
                begin
                    if (!ptr_end)
                    begin
                        ptr_reg <= ptr_reg + PTR_W'(1);
                    end
                    else if (!sc1_v_reg && !sc2_v_reg)
                    begin
                        state_reg <= ST_SIG;
                    end
                end
                ST_SIG:
                begin
                    prob_reg  <= SIG_ROM[sig_idx];
                    pred_reg  <= !acc_reg[ACC_W-1];
                    match_reg <= (!acc_reg[ACC_W-1]) == label_reg;
                    state_reg <= ST_GRAD1;
                end
                ST_GRAD1:
                begin
                    err_reg   <= label_reg ? $signed(18'd65536 - 18'(pc)) : -$signed(18'(pc));
                    g_reg     <= g_full[32:16];
                    state_reg <= ST_GRAD2;
                end
                ST_GRAD2:
                begin
                    el_reg    <= 35'(err_reg * $signed({1'b0, lr_reg}));
                    state_reg <= ST_GRAD3;
                end
                ST_GRAD3:
                begin
                    s_reg     <= S_W'(el_reg * $signed({1'b0, g_reg}));
                    ptr_reg   <= '0;
                    state_reg <= ST_TRAIN;
                end
                ST_TRAIN:
                begin
                    if (!ptr_end)
                    begin
                        ptr_reg <= ptr_reg + PTR_W'(1);
                    end
                    else if (!tr1_v_reg && !tr2_v_reg)
                    begin
                        if (train_reg)
                            bias_reg <= sat_wgt(b_sum);
                        ptr_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
